// ===== rtl/apir_pkg.sv =====
// ----------------------------------------------------------------------------
// apir_pkg
// Shared constants for the average-predictor image reconstruction unit.
// ----------------------------------------------------------------------------
package apir_pkg;

  // Design-size defaults
  localparam int MAX_WIDTH_DEF    = 4096;
  localparam int MAX_CHANNELS_DEF = 4;

  // Fixed field widths
  localparam int BYTE_W     = 8;
  localparam int CH_W       = 2;
  localparam int LEFT_DEPTH = 4;
  localparam int ROW_W      = 16;
  localparam int CMP_W      = 17;

  // Configuration port
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 16;
  localparam int CFG_WIDTH_W  = 13;
  localparam int CFG_HEIGHT_W = 16;
  localparam int CFG_BPP_W    = 3;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BYTES_PER_PIXEL = 2'd2;

endpackage

// ===== rtl/apir_ram.sv =====
// ----------------------------------------------------------------------------
// apir_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module apir_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/average_predictor_image_reconstruct_unit.sv =====
// ----------------------------------------------------------------------------
// average_predictor_image_reconstruct_unit
// Rebuilds channel bytes from residuals with a left/above/average predictor.
// ----------------------------------------------------------------------------
// An accepted input passes the compute stage and the output register to out_valid.
// Throughput: one byte per cycle unless a stalled output holds the pipe; the line store
//   is read in the accept cycle and written back as s1 retires (one read, one write port).
// Reset (synchronous, rst_n low): counters, left bytes and pipeline valids
//   clear, registers return to 1. The line store is not cleared.
module average_predictor_image_reconstruct_unit
  import apir_pkg::*;
#(
  parameter int MAX_WIDTH    = MAX_WIDTH_DEF,
  parameter int MAX_CHANNELS = MAX_CHANNELS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // configuration
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  // residual stream
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [BYTE_W-1:0]     in_residual,
  // reconstructed stream
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [BYTE_W-1:0]     out_pixel_byte,
  output logic                  out_frame_end
);

  localparam int DEPTH  = MAX_WIDTH * MAX_CHANNELS;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int COL_W  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

  // Per-byte control carried from the accept stage to the compute stage
  typedef struct packed {
    logic              first_row;
    logic              first_col;
    logic              frame_end;
    logic [CH_W-1:0]   ch;
    logic [ADDR_W-1:0] addr;
    logic [BYTE_W-1:0] residual;
  } s1_t;

  // --------------------------------------------------------------------------
  // Configuration registers and effective (saturated) values
  // --------------------------------------------------------------------------
  logic [CFG_WIDTH_W-1:0]  cfg_width_r;
  logic [CFG_HEIGHT_W-1:0] cfg_height_r;
  logic [CFG_BPP_W-1:0]    cfg_bpp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_width_r  <= CFG_WIDTH_W'(1);
      cfg_height_r <= CFG_HEIGHT_W'(1);
      cfg_bpp_r    <= CFG_BPP_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_IMAGE_WIDTH:     cfg_width_r  <= cfg_wdata[CFG_WIDTH_W-1:0];
        CFG_IMAGE_HEIGHT:    cfg_height_r <= cfg_wdata[CFG_HEIGHT_W-1:0];
        CFG_BYTES_PER_PIXEL: cfg_bpp_r    <= cfg_wdata[CFG_BPP_W-1:0];
        default: ;  // unused index, write dropped
      endcase
    end
  end

  logic [CMP_W-1:0]     w_eff;
  logic [CMP_W-1:0]     h_eff;
  logic [CFG_BPP_W-1:0] bpp_eff;

  always_comb begin
    w_eff = CMP_W'(cfg_width_r);
    if (w_eff == '0) begin
      w_eff = CMP_W'(1);
    end else if (w_eff > CMP_W'(MAX_WIDTH)) begin
      w_eff = CMP_W'(MAX_WIDTH);
    end

    h_eff = CMP_W'(cfg_height_r);
    if (h_eff == '0) begin
      h_eff = CMP_W'(1);
    end

    bpp_eff = cfg_bpp_r;
    if (bpp_eff == '0) begin
      bpp_eff = CFG_BPP_W'(1);
    end else if (bpp_eff > CFG_BPP_W'(MAX_CHANNELS)) begin
      bpp_eff = CFG_BPP_W'(MAX_CHANNELS);
    end
  end

  // --------------------------------------------------------------------------
  // Handshake / pipeline control
  //   s1 = compute stage (line store data valid), out = output register.
  // --------------------------------------------------------------------------
  logic s1_valid_r;
  logic out_valid_r;
  logic s1_adv;
  logic in_acc;

  assign s1_adv   = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !s1_adv;
  assign in_acc   = in_valid && !in_stall;

  // --------------------------------------------------------------------------
  // Raster counters (advance on each accepted transaction)
  // --------------------------------------------------------------------------
  logic [CH_W-1:0]  ch_r;
  logic [COL_W-1:0] col_r;
  logic [ROW_W-1:0] row_r;
  logic             ch_last;
  logic             col_last;
  logic             row_last;
  logic [ADDR_W-1:0] rd_addr;

  assign ch_last  = (CFG_BPP_W'(ch_r) + CFG_BPP_W'(1)) >= bpp_eff;
  assign col_last = (CMP_W'(col_r) + CMP_W'(1)) >= w_eff;
  assign row_last = (CMP_W'(row_r) + CMP_W'(1)) >= h_eff;
  // entry = column * MAX_CHANNELS + channel; column never reaches MAX_WIDTH
  assign rd_addr  = ADDR_W'(int'(col_r) * MAX_CHANNELS + int'(ch_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ch_r  <= '0;
      col_r <= '0;
      row_r <= '0;
    end else if (in_acc) begin
      if (ch_last) begin
        ch_r <= '0;
        if (col_last) begin
          col_r <= '0;
          row_r <= row_last ? '0 : row_r + ROW_W'(1);
        end else begin
          col_r <= col_r + COL_W'(1);
        end
      end else begin
        ch_r <= ch_r + CH_W'(1);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Line store: read at accept, write back when the compute stage retires.
  // --------------------------------------------------------------------------
  s1_t               s1_r;
  logic [BYTE_W-1:0] above_ram;
  logic [BYTE_W-1:0] result;

  apir_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (DEPTH),
    .ADDR_W(ADDR_W)
  ) u_row_store (
    .clk  (clk),
    .we   (s1_adv),
    .waddr(s1_r.addr),
    .wdata(result),
    .re   (in_acc),
    .raddr(rd_addr),
    .rdata(above_ram)
  );

  // Same-entry read and write on one edge (one-byte rows): forward the
  // byte being written instead of the stale RAM word.
  logic              fwd_sel_r;
  logic [BYTE_W-1:0] fwd_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_sel_r <= 1'b0;
    end else if (in_acc) begin
      fwd_sel_r <= s1_adv && (s1_r.addr == rd_addr);
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      fwd_data_r <= result;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1 register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_r.first_row <= (row_r == '0);
      s1_r.first_col <= (col_r == '0);
      s1_r.frame_end <= ch_last && col_last && row_last;
      s1_r.ch        <= ch_r;
      s1_r.addr      <= rd_addr;
      s1_r.residual  <= in_residual;
    end
  end

  // --------------------------------------------------------------------------
  // Prediction and reconstruction
  // --------------------------------------------------------------------------
  logic [BYTE_W-1:0] left_r [LEFT_DEPTH];
  logic [BYTE_W-1:0] left;
  logic [BYTE_W-1:0] above;
  logic [BYTE_W:0]   avg_sum;
  logic [BYTE_W-1:0] pred;

  assign left    = left_r[s1_r.ch];
  assign above   = fwd_sel_r ? fwd_data_r : above_ram;
  assign avg_sum = {1'b0, left} + {1'b0, above};

  always_comb begin
    if (s1_r.first_row && s1_r.first_col) begin
      pred = '0;
    end else if (s1_r.first_row) begin
      pred = left;
    end else if (s1_r.first_col) begin
      pred = above;
    end else begin
      pred = avg_sum[BYTE_W:1];
    end
  end

  assign result = s1_r.residual + pred;  // wraps mod 256

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LEFT_DEPTH; i++) begin
        left_r[i] <= '0;
      end
    end else if (s1_adv) begin
      left_r[s1_r.ch] <= result;
    end
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  logic [BYTE_W-1:0] out_byte_r;
  logic              out_end_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_byte_r <= result;
      out_end_r  <= s1_r.frame_end;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_pixel_byte = out_byte_r;
  assign out_frame_end  = out_end_r;

endmodule

// ===== rtl/apir_checker.sv =====
// ----------------------------------------------------------------------------
// apir_checker
// Port-level checks for the reconstruction unit, bound to the top level.
// ----------------------------------------------------------------------------
module apir_checker
  import apir_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_stall,
  input logic                  out_valid,
  input logic                  out_stall,
  input logic [BYTE_W-1:0]     out_pixel_byte,
  input logic                  out_frame_end
);

  // Held result stays put while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_pixel_byte)
      && $stable(out_frame_end))
    else $error("result changed while stalled");

  // Reset empties the output
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("out_valid set after reset");

  // Input backpressure only when the output is blocked
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with free output");

  // A new result follows an accepted transaction through the compute stage and output register
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
    else $error("result without matching input transaction");

  // One result per input: a clean pipe passes an accept through to the output register
  a_out_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && !out_valid |=> ##1 out_valid)
    else $error("accepted transaction produced no result");

endmodule

bind average_predictor_image_reconstruct_unit apir_checker u_apir_checker (.*);

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the average-predictor image reconstruction unit.
// A scoreboard class predicts every reconstructed byte and its frame-end flag
// from the accepted residual transactions and the register settings. Plain
// tasks drive residuals, register writes and random back-pressure.
// ----------------------------------------------------------------------------
module testbench;
  import apir_pkg::*;

  // Index past the register list: a write there must be dropped
  localparam logic [CFG_IDX_W-1:0] CFG_BAD_INDEX = 2'd3;
  localparam int STORE_DEPTH = MAX_WIDTH_DEF * MAX_CHANNELS_DEF;

  typedef struct packed {
    logic [BYTE_W-1:0] pixel_byte;
    logic              frame_end;
  } recon_byte_t;

  // --------------------------------------------------------------------------
  // Scoreboard: own copy of registers, counters, line store and left bytes.
  // --------------------------------------------------------------------------
  class reconstruct_scoreboard;
    bit [BYTE_W-1:0]       line_store [STORE_DEPTH];
    bit [BYTE_W-1:0]       left_byte [LEFT_DEPTH];
    bit [11:0]             column_idx;
    bit [CH_W-1:0]         channel_idx;
    bit [ROW_W-1:0]        row_idx;
    bit [CFG_WIDTH_W-1:0]  width_reg;
    bit [CFG_HEIGHT_W-1:0] height_reg;
    bit [CFG_BPP_W-1:0]    bpp_reg;
    recon_byte_t           expected_bytes [$];
    int                    errors;

    function new();
      width_reg  = 1;
      height_reg = 1;
      bpp_reg    = 1;
      errors     = 0;
    endfunction

    static function int clamp(int v, int lo, int hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
    endfunction

    function int eff_width();
      return clamp(int'(width_reg), 1, MAX_WIDTH_DEF);
    endfunction

    function int eff_height();
      return clamp(int'(height_reg), 1, 65535);
    endfunction

    function int eff_bpp();
      return clamp(int'(bpp_reg), 1, MAX_CHANNELS_DEF);
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_IMAGE_WIDTH:     width_reg  = data[CFG_WIDTH_W-1:0];
        CFG_IMAGE_HEIGHT:    height_reg = data[CFG_HEIGHT_W-1:0];
        CFG_BYTES_PER_PIXEL: bpp_reg    = data[CFG_BPP_W-1:0];
        default: ;
      endcase
    endfunction

    // Raster advance; a counter at or past its limit wraps on this byte.
    function bit step_counters(inout bit [11:0] c, inout bit [CH_W-1:0] k,
                               inout bit [ROW_W-1:0] r);
      bit fe;
      fe = 1'b0;
      if (int'(k) + 1 >= eff_bpp()) begin
        k = 0;
        if (int'(c) + 1 >= eff_width()) begin
          c = 0;
          if (int'(r) + 1 >= eff_height()) begin
            r  = 0;
            fe = 1'b1;
          end else begin
            r++;
          end
        end else begin
          c++;
        end
      end else begin
        k++;
      end
      return fe;
    endfunction

    function bit at_frame_start();
      return column_idx == 0 && channel_idx == 0 && row_idx == 0;
    endfunction

    // Bytes left up to and including the frame's last one, saturated at cap
    function int bytes_to_frame_end(int cap);
      bit [11:0]      c;
      bit [CH_W-1:0]  k;
      bit [ROW_W-1:0] r;
      int             n;
      c = column_idx;
      k = channel_idx;
      r = row_idx;
      n = 1;
      while (!step_counters(c, k, r) && n < cap) n++;
      return n;
    endfunction

    function void note_residual(logic [BYTE_W-1:0] residual);
      int              addr;
      int              left_v;
      int              above_v;
      int              pred;
      bit [BYTE_W-1:0] pixel;
      bit              fe;
      addr    = int'(column_idx) * MAX_CHANNELS_DEF + int'(channel_idx);
      left_v  = left_byte[channel_idx];
      above_v = line_store[addr];
      if (row_idx == 0 && column_idx == 0) pred = 0;
      else if (row_idx == 0)               pred = left_v;
      else if (column_idx == 0)            pred = above_v;
      else                                 pred = (left_v + above_v) >> 1;
      pixel                  = BYTE_W'(int'(residual) + pred);
      line_store[addr]       = pixel;
      left_byte[channel_idx] = pixel;
      fe = step_counters(column_idx, channel_idx, row_idx);
      expected_bytes.push_back('{pixel_byte: pixel, frame_end: fe});
    endfunction

    function void report_mismatch(string msg);
      $display("%0t ns: mismatch: %s", $time, msg);
      errors++;
    endfunction

    function void check_pixel(logic [BYTE_W-1:0] pixel, logic fe);
      recon_byte_t exp_b;
      if (expected_bytes.size() == 0) begin
        report_mismatch($sformatf("unexpected byte %02h frame_end %0b", pixel, fe));
        return;
      end
      exp_b = expected_bytes.pop_front();
      if (pixel !== exp_b.pixel_byte)
        report_mismatch($sformatf("pixel_byte %02h, expected %02h",
                                  pixel, exp_b.pixel_byte));
      if (fe !== exp_b.frame_end)
        report_mismatch($sformatf("frame_end %0b, expected %0b", fe, exp_b.frame_end));
    endfunction

    function int pending();
      return expected_bytes.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // DUT signals; the inputs driven by the bench are known from time zero
  // --------------------------------------------------------------------------
  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [BYTE_W-1:0]     in_residual = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [BYTE_W-1:0]     out_pixel_byte;
  logic                  out_frame_end;

  reconstruct_scoreboard sb;
  bit                    steady = 1'b0;  // phase with no idling on either side
  int                    items_sent = 0;

  // Directed frame: 3 x 2 pixels of 2 channels, walks every predictor case
  // with bytes that overflow the 8-bit result and fill the 9-bit sum.
  logic [BYTE_W-1:0] corner_frame [12] = '{
    8'hff, 8'h00, 8'hff, 8'h80, 8'h01, 8'hff,
    8'h01, 8'hff, 8'hff, 8'hff, 8'h00, 8'h01
  };

  average_predictor_image_reconstruct_unit i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_residual    (in_residual),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_pixel_byte (out_pixel_byte),
    .out_frame_end  (out_frame_end)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Idle length: mostly none or short, now and then a long one
  function automatic int gap_len();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 15);
    return $urandom_range(20, 60);
  endfunction

  // Config writes happen only with the pipeline drained (every item yields
  // one result, so an empty expectation queue means the block is idle).
  task automatic wait_idle();
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    wait_idle();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.write_reg(idx, data);
  endtask

  // One residual transaction; returns at the edge that accepted it
  task automatic send_residual(input logic [BYTE_W-1:0] residual);
    int g;
    g = gap_len();
    repeat (g) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid    <= 1'b1;
    in_residual <= residual;
    do @(posedge clk); while (in_stall);
    sb.note_residual(residual);
    items_sent++;
  endtask

  // Burst of random residuals; valid drops afterwards so nothing leaks in
  task automatic send_items(input int n);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 9);
      if (r == 0)      send_residual(8'h00);
      else if (r == 1) send_residual(8'hff);
      else             send_residual(BYTE_W'($urandom));
    end
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // Bring the counters back to the frame start. A short remainder is sent
  // as is; a long one is cut by shrinking all three registers to 1.
  task automatic finish_frame();
    int n;
    if (sb.at_frame_start()) return;
    n = sb.bytes_to_frame_end(401);
    if (n <= 400) begin
      send_items(n);
    end else begin
      write_reg(CFG_IMAGE_WIDTH, 16'd1);
      write_reg(CFG_BYTES_PER_PIXEL, 16'd1);
      write_reg(CFG_IMAGE_HEIGHT, 16'd1);
      send_items(1);
    end
  endtask

  // Random register settings. Mid-frame, width and channel count may only
  // shrink so the line store is never read where this frame did not write.
  task automatic random_config(input bit mid_frame);
    logic [CFG_DATA_W-1:0] d;
    int                    r;
    if ($urandom_range(0, 3) != 0) begin
      d = CFG_DATA_W'($urandom);
      r = $urandom_range(0, 99);
      if (r < 75)      d[CFG_WIDTH_W-1:0] = CFG_WIDTH_W'($urandom_range(1, 8));
      else if (r < 88) d[CFG_WIDTH_W-1:0] = CFG_WIDTH_W'($urandom_range(9, 64));
      else if (r < 92) d[CFG_WIDTH_W-1:0] = '0;
      else if (r < 96) d[CFG_WIDTH_W-1:0] = CFG_WIDTH_W'(MAX_WIDTH_DEF);
      else d[CFG_WIDTH_W-1:0] = CFG_WIDTH_W'($urandom_range(MAX_WIDTH_DEF + 1, 8191));
      if (!mid_frame ||
          reconstruct_scoreboard::clamp(int'(d[CFG_WIDTH_W-1:0]), 1, MAX_WIDTH_DEF)
          <= sb.eff_width())
        write_reg(CFG_IMAGE_WIDTH, d);
    end
    if ($urandom_range(0, 3) != 0) begin
      r = $urandom_range(0, 99);
      if (r < 75)      d = CFG_DATA_W'($urandom_range(1, 4));
      else if (r < 85) d = CFG_DATA_W'($urandom_range(5, 16));
      else if (r < 90) d = '0;
      else if (r < 95) d = 16'hffff;
      else             d = CFG_DATA_W'($urandom);
      write_reg(CFG_IMAGE_HEIGHT, d);
    end
    if ($urandom_range(0, 3) != 0) begin
      d = CFG_DATA_W'($urandom);
      if ($urandom_range(0, 99) < 85)
        d[CFG_BPP_W-1:0] = CFG_BPP_W'($urandom_range(1, MAX_CHANNELS_DEF));
      if (!mid_frame ||
          reconstruct_scoreboard::clamp(int'(d[CFG_BPP_W-1:0]), 1, MAX_CHANNELS_DEF)
          <= sb.eff_bpp())
        write_reg(CFG_BYTES_PER_PIXEL, d);
    end
    if ($urandom_range(0, 9) == 0) write_reg(CFG_BAD_INDEX, CFG_DATA_W'($urandom));
  endtask

  // Result side: random stall runs; stall only changes on the falling edge
  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall  <= 1'b0;
        stall_left = gap_len();
      end
    end
  end

  // Result monitor: a transaction is valid high, stall low at the rising edge
  initial begin
    forever begin
      @(posedge clk);
      if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
        sb.check_pixel(out_pixel_byte, out_frame_end);
    end
  end

  // Hard limit, far above the slowest legal run
  initial begin
    #(20_000_000);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Main sequence
  initial begin
    int n;
    sb = new();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // --- directed part ---
    // Reset settings: every byte is a first pixel and ends a frame
    send_residual(8'h00);
    send_residual(8'hff);
    send_residual(8'h80);
    @(negedge clk);
    in_valid <= 1'b0;

    // Small full frame: pass-through, left, above and average predictors
    write_reg(CFG_IMAGE_WIDTH, 16'd3);
    write_reg(CFG_IMAGE_HEIGHT, 16'd2);
    write_reg(CFG_BYTES_PER_PIXEL, 16'd2);
    foreach (corner_frame[i]) send_residual(corner_frame[i]);
    @(negedge clk);
    in_valid <= 1'b0;

    // Upper bits masked, out-of-range values saturate: width 8191 -> 4096,
    // height 0 -> 1, 7 channels -> 4
    write_reg(CFG_IMAGE_WIDTH, 16'hffff);
    write_reg(CFG_IMAGE_HEIGHT, 16'h0000);
    write_reg(CFG_BYTES_PER_PIXEL, 16'hffff);
    repeat (4) send_residual(8'hff);
    @(negedge clk);
    in_valid <= 1'b0;

    // Mid-frame shrink: column past the new limit wraps on the next byte;
    // width 0 and channel count 0 act as 1
    write_reg(CFG_IMAGE_WIDTH, 16'h0000);
    write_reg(CFG_IMAGE_HEIGHT, 16'hffff);
    write_reg(CFG_BYTES_PER_PIXEL, 16'h0000);
    send_residual(8'h80);
    send_residual(8'h7f);
    send_residual(8'h00);
    send_residual(8'hff);
    @(negedge clk);
    in_valid <= 1'b0;

    // Write to an index past the list is dropped
    write_reg(CFG_BAD_INDEX, 16'h0000);
    send_residual(8'h55);
    send_residual(8'haa);
    @(negedge clk);
    in_valid <= 1'b0;

    // --- random part ---
    while (items_sent < 1000) begin
      steady = ($urandom_range(0, 5) == 0);
      if (sb.at_frame_start() || $urandom_range(0, 3) != 0) begin
        // Well-formed frames with random content
        finish_frame();
        random_config(1'b0);
        n = sb.bytes_to_frame_end(201);
        if (n <= 200) send_items(n * $urandom_range(1, 3));
        else          send_items($urandom_range(1, 60));
      end else begin
        // Register change in the middle of a frame
        random_config(1'b1);
        send_items($urandom_range(1, 40));
      end
    end

    // Drain, then allow the pipeline latency for stray results
    steady = 1'b0;
    wait_idle();
    repeat (10) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
